// File: rtl/core/wildcard_pattern_matcher_macros.svh
// Assertion macros for the wildcard pattern matcher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
// Used by wpm_cell and wildcard_pattern_matcher; no dependencies.
package wpm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int LEN_OUT_W       = 7;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_BEGIN  = 2'd2,
        CMD_TEXT   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] symbol;
    } item_t;

    typedef struct packed {
        logic                 matched;
        logic                 overflow;
        logic [LEN_OUT_W-1:0] pattern_length;
    } result_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic       load;
        logic       feed;
        logic       write;
        logic [7:0] symbol;
    } cell_ctrl_t;

    // Passed from one cell to the next.
    typedef struct packed {
        logic step;
        logic close;
    } link_t;

endpackage

// File: rtl/core/wpm_cell.sv
// One pattern position: stored pattern byte and its active flag.
// Depends on wpm_pkg; chained by wildcard_pattern_matcher.
module wpm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wpm_pkg::cell_ctrl_t ctrl,
    input  logic [LEN_W-1:0]   len_cur,
    input  logic [LEN_W-1:0]   len_new,
    input  wpm_pkg::link_t     link_in,
    output wpm_pkg::link_t     link_out,
    output logic               active,
    output logic               hit
);
    import wpm_pkg::*;

    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       active_reg;
    logic       active_next;
    logic       wr;
    logic [7:0] byte_eff;
    logic       used;
    logic       is_star;
    logic       fits;
    logic       pre;
    logic       post;

    always_comb
    begin
        wr       = ctrl.write && (len_cur == LEN_W'(IDX));
        byte_eff = wr ? ctrl.symbol : pat_reg;
        used     = LEN_W'(IDX) < len_new;
        is_star  = byte_eff == STAR_BYTE;
        fits     = (byte_eff == ANY_BYTE) || (byte_eff == ctrl.symbol);

        pre  = (ctrl.feed && active_reg && used && is_star) || link_in.step;
        post = pre || link_in.close;

        link_out.close = post && used && is_star;
        link_out.step  = ctrl.feed && active_reg && used && !is_star && fits;

        hit         = post && (len_new == LEN_W'(IDX));
        active_next = ctrl.load ? post : active_reg;
        pat_next    = wr ? ctrl.symbol : pat_reg;
    end

    assign active = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (IDX == 0);
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

endmodule

// File: rtl/core/wildcard_pattern_matcher.sv
// Whole-string wildcard matcher ('*' any run, '?' any one byte).
// Top level: a row of wpm_cell positions plus the end-of-pattern flag.
// Depends on wpm_pkg, wpm_cell and wildcard_pattern_matcher_macros.svh.
//
// Usage: one input channel (item_valid/item_stall/item) carries commands:
// clear pattern, append pattern byte, begin new text, feed text byte.
// Each transaction yields exactly one result transaction on the output
// channel (result_valid/result_stall/result): whether the text so far
// matches the whole pattern, an overflow flag for refused appends, and
// the stored pattern length.
// Throughput: one transaction per cycle while item_stall is low. The result
// is valid the cycle after the item is accepted. The per-item update,
// including star closure, ripples once through the cell row in the accept cycle.
// Stall: while a result is held and result_stall is high, item_stall is
// raised; the result register keeps its value until taken.
// Reset: pattern empty, only position zero active, no result pending.
`include "wildcard_pattern_matcher_macros.svh"

module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  wpm_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output wpm_pkg::result_t result
);
    import wpm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [LEN_W-1:0]   len_new;
    logic               end_reg;
    logic               end_next;
    logic               end_post;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;

    logic               accept;
    logic               full;
    logic               append_ok;
    cell_ctrl_t         ctrl;
    link_t              links [0:MAX_PATTERN];
    logic [MAX_PATTERN-1:0] act_vec;
    logic [MAX_PATTERN:0]   hit_vec;
    logic [MAX_PATTERN:0]   act_all;

    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign full       = len_reg == LEN_W'(MAX_PATTERN);
    assign append_ok  = (item.cmd == CMD_APPEND) && !full;

    always_comb
    begin
        unique case (item.cmd)
            CMD_CLEAR:  len_new = '0;
            CMD_APPEND: len_new = append_ok ? len_reg + LEN_W'(1) : len_reg;
            CMD_BEGIN:  len_new = len_reg;
            CMD_TEXT:   len_new = len_reg;
        endcase

        ctrl.load   = accept && !((item.cmd == CMD_APPEND) && full);
        ctrl.feed   = item.cmd == CMD_TEXT;
        ctrl.write  = accept && append_ok;
        ctrl.symbol = item.symbol;
    end

    assign links[0].step  = item.cmd != CMD_TEXT;
    assign links[0].close = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            wpm_cell #(
                .IDX   (g),
                .LEN_W (LEN_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .len_cur  (len_reg),
                .len_new  (len_new),
                .link_in  (links[g]),
                .link_out (links[g+1]),
                .active   (act_vec[g]),
                .hit      (hit_vec[g])
            );
        end
    endgenerate

    assign end_post             = links[MAX_PATTERN].step || links[MAX_PATTERN].close;
    assign hit_vec[MAX_PATTERN] = end_post && (len_new == LEN_W'(MAX_PATTERN));

    always_comb
    begin
        end_next = ctrl.load ? end_post : end_reg;
        len_next = accept ? len_new : len_reg;
        act_all  = {end_reg, act_vec};

        result_next.matched  = (|hit_vec) &&
                               ((item.cmd == CMD_BEGIN) || (item.cmd == CMD_TEXT));
        result_next.overflow = (item.cmd == CMD_APPEND) && full;
        result_next.pattern_length = LEN_OUT_W'(len_new);

        result_valid_next = accept || item_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            end_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            end_reg          <= end_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `WPM_ASSERT_SAME(a_overflow_full, clk, rst_n,
        result_valid_reg && result_reg.overflow,
        !result_reg.matched && (result_reg.pattern_length == LEN_OUT_W'(MAX_PATTERN)),
        "overflow reported without a full pattern store")
    `WPM_ASSERT_NEXT(a_clear_state, clk, rst_n,
        accept && (item.cmd == CMD_CLEAR),
        (len_reg == '0) && (act_all == (MAX_PATTERN + 1)'(1)),
        "clear did not reset length and active set")
    `WPM_ASSERT_SAME(a_active_bound, clk, rst_n,
        1'b1,
        (act_all >> len_reg) <= (MAX_PATTERN + 1)'(1),
        "active position beyond pattern length")
    `WPM_ASSERT_NEXT(a_append_len, clk, rst_n,
        accept && append_ok,
        (len_reg == $past(len_reg) + LEN_W'(1)) && act_all[0],
        "append did not grow length or restart text")

endmodule
